// File: rtl/core/ssip_pkg.sv
package ssip_pkg;

    localparam int LINE_DEPTH     = 10;
    localparam int LINE_AW        = $clog2(LINE_DEPTH);
    localparam int GAIN_FRAC_BITS = 16;

    localparam int GAIN_W   = 24;
    localparam int DRIVE_W  = 16;
    localparam int TARGET_W = 32;
    localparam int BYTE_W   = 8;
    localparam int ERR_W    = TARGET_W + 1;
    localparam int D1_W     = ERR_W + 1;
    localparam int D2_W     = ERR_W + 2;
    localparam int PROD_W   = GAIN_W + D2_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int DELTA_W  = ACC_W - GAIN_FRAC_BITS;
    localparam int VAL_W    = DELTA_W + 1;
    localparam int MAG_W    = TARGET_W;
    localparam int MAG_X_W  = MAG_W + 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOWER = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd6554;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 16'd39999;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_DRIVE  = 1'b0;
    localparam logic KIND_TARGET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PARSE,
        ST_PFIN,
        ST_PSET,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_DELTA,
        ST_CLAMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGIT,
        PH_STOP
    } phase_t;

endpackage

// File: rtl/core/ssip_ram.sv
module ssip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/serial_setpoint_incremental_pid_unit.sv
// serial setpoint incremental pid unit
// input channel s_axis: tuser selects the item kind (0 = serial byte in tdata,
// 1 = control tick). output channel m_axis: tuser is the result kind
// (0 = drive after a tick, 1 = target after a newline), tdata carries the
// current drive and target.
// a plain byte is written to the line memory in the cycle it is taken and
// gives no result. a newline walks the line memory one entry a cycle through
// its registered read port. a tick runs the three gain products through one
// shared multiplier, then truncates, adds and clamps. one item is in work at
// a time; tready is high only while the controller is idle.
// the finished result sits in an output register, so a new item is taken
// while m_axis is stalled; a second result waits in the done step until the
// register frees up.
// reset restores the default gains and bounds, a drive of 39999, a zero
// target and error history, and an empty line (per-entry valid bits, so no
// clearing pass is needed). configuration writes go to cfg_* at any edge.
module serial_setpoint_incremental_pid_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] drive_value, [47:16] target_value
    output logic        m_axis_tuser,   // [0] result_kind

    input  logic        cfg_we,
    input  logic [ssip_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssip_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = ssip_pkg::LINE_AW;

    // configuration
    logic signed [ssip_pkg::GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [ssip_pkg::DRIVE_W-1:0]       drive_upper_reg, drive_lower_reg;

    // control state
    ssip_pkg::state_t state_reg, state_next;
    ssip_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0]                   wpos_reg, wpos_next;
    logic [AW-1:0]                   rd_cnt_reg, rd_cnt_next;
    logic [ssip_pkg::LINE_DEPTH-1:0] line_valid_reg, line_valid_next;
    logic                            pend_reg, pend_next;
    logic                            byte_ok_reg, byte_ok_next;
    logic                            neg_reg, neg_next;
    logic [ssip_pkg::MAG_W-1:0]      mag_reg, mag_next;
    logic                            kind_reg, kind_next;
    logic                            out_valid_reg, out_valid_next;

    // controller state
    logic signed [ssip_pkg::TARGET_W-1:0] setpoint_reg, setpoint_next;
    logic [ssip_pkg::DRIVE_W-1:0]         drive_reg, drive_next;
    logic signed [ssip_pkg::ERR_W-1:0]    e1_reg, e1_next, e2_reg, e2_next;

    // datapath
    logic signed [ssip_pkg::ERR_W-1:0]   e_reg, e_next;
    logic signed [ssip_pkg::D1_W-1:0]    d1_reg, d1_next;
    logic signed [ssip_pkg::D2_W-1:0]    d2_reg, d2_next;
    logic signed [ssip_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ssip_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ssip_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [47:0]                         out_data_reg, out_data_next;
    logic                                out_kind_reg, out_kind_next;

    // line memory
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [ssip_pkg::BYTE_W-1:0]   ram_wdata;
    logic [ssip_pkg::BYTE_W-1:0]   ram_rdata;

    logic in_take;
    logic out_free;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ssip_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;

    ssip_ram #(
        .WIDTH (ssip_pkg::BYTE_W),
        .DEPTH (ssip_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= ssip_pkg::GAIN_RESET;
            gain_i_reg      <= ssip_pkg::GAIN_RESET;
            gain_d_reg      <= '0;
            drive_upper_reg <= ssip_pkg::DRIVE_RESET;
            drive_lower_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssip_pkg::CFG_GAIN_P:      gain_p_reg      <= cfg_wdata;
                ssip_pkg::CFG_GAIN_I:      gain_i_reg      <= cfg_wdata;
                ssip_pkg::CFG_GAIN_D:      gain_d_reg      <= cfg_wdata;
                ssip_pkg::CFG_DRIVE_UPPER: drive_upper_reg <= cfg_wdata[ssip_pkg::DRIVE_W-1:0];
                ssip_pkg::CFG_DRIVE_LOWER: drive_lower_reg <= cfg_wdata[ssip_pkg::DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssip_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (s_axis_tuser == ssip_pkg::OP_TICK)
                    begin
                        state_next = ssip_pkg::ST_ERR;
                    end
                    else if (s_axis_tdata == ssip_pkg::CHAR_NEWLINE)
                    begin
                        state_next = ssip_pkg::ST_PARSE;
                    end
                end
            end
            ssip_pkg::ST_PARSE:
            begin
                if (rd_cnt_reg == AW'(ssip_pkg::LINE_DEPTH - 1))
                begin
                    state_next = ssip_pkg::ST_PFIN;
                end
            end
            ssip_pkg::ST_PFIN:  state_next = ssip_pkg::ST_PSET;
            ssip_pkg::ST_PSET:  state_next = ssip_pkg::ST_DONE;
            ssip_pkg::ST_ERR:   state_next = ssip_pkg::ST_MUL_P;
            ssip_pkg::ST_MUL_P: state_next = ssip_pkg::ST_MUL_I;
            ssip_pkg::ST_MUL_I: state_next = ssip_pkg::ST_MUL_D;
            ssip_pkg::ST_MUL_D: state_next = ssip_pkg::ST_ACC;
            ssip_pkg::ST_ACC:   state_next = ssip_pkg::ST_DELTA;
            ssip_pkg::ST_DELTA: state_next = ssip_pkg::ST_CLAMP;
            ssip_pkg::ST_CLAMP: state_next = ssip_pkg::ST_DONE;
            ssip_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ssip_pkg::ST_IDLE;
                end
            end
            default: state_next = ssip_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    logic [ssip_pkg::BYTE_W-1:0]   cur_byte;
    logic                          is_blank, is_digit, is_sign;
    logic [ssip_pkg::MAG_X_W-1:0]  mag_x, mag_cap;
    logic signed [ssip_pkg::GAIN_W-1:0] mul_a;
    logic signed [ssip_pkg::D2_W-1:0]   mul_b;
    logic signed [ssip_pkg::VAL_W-1:0]  v_sum;
    logic                               low_nz;

    always_comb
    begin
        cur_byte = byte_ok_reg ? ram_rdata : '0;
        is_blank = (cur_byte == ssip_pkg::CHAR_SPACE)
                || (cur_byte >= ssip_pkg::CHAR_TAB && cur_byte <= ssip_pkg::CHAR_CR);
        is_digit = (cur_byte >= ssip_pkg::CHAR_ZERO) && (cur_byte <= ssip_pkg::CHAR_NINE);
        is_sign  = (cur_byte == ssip_pkg::CHAR_PLUS) || (cur_byte == ssip_pkg::CHAR_MINUS);
        mag_x    = (ssip_pkg::MAG_X_W'(mag_reg) << 3) + (ssip_pkg::MAG_X_W'(mag_reg) << 1)
                 + ssip_pkg::MAG_X_W'(cur_byte[3:0]);
        mag_cap  = neg_reg ? (ssip_pkg::MAG_X_W'(1) << (ssip_pkg::TARGET_W - 1))
                           : ((ssip_pkg::MAG_X_W'(1) << (ssip_pkg::TARGET_W - 1)) - 1'b1);

        mul_a = gain_p_reg;
        mul_b = ssip_pkg::D2_W'(e_reg);
        case (state_reg)
            ssip_pkg::ST_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = ssip_pkg::D2_W'(d1_reg);
            end
            ssip_pkg::ST_MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = d2_reg;
            end
            default: ;
        endcase

        low_nz = |acc_reg[ssip_pkg::GAIN_FRAC_BITS-1:0];
        v_sum  = $signed(ssip_pkg::VAL_W'(drive_reg)) + ssip_pkg::VAL_W'(delta_reg);

        wpos_next       = wpos_reg;
        rd_cnt_next     = rd_cnt_reg;
        line_valid_next = line_valid_reg;
        pend_next       = 1'b0;
        byte_ok_next    = line_valid_reg[rd_cnt_reg];
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        kind_next       = kind_reg;
        setpoint_next   = setpoint_reg;
        drive_next      = drive_reg;
        e1_next         = e1_reg;
        e2_next         = e2_reg;
        e_next          = e_reg;
        d1_next         = d1_reg;
        d2_next         = d2_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        delta_next      = delta_reg;
        out_data_next   = out_data_reg;
        out_kind_next   = out_kind_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;
        ram_waddr       = wpos_reg;
        ram_wdata       = s_axis_tdata;

        // one parse step for the byte read in the previous cycle
        if (pend_reg)
        begin
            case (phase_reg)
                ssip_pkg::PH_BLANK:
                begin
                    if (is_sign)
                    begin
                        neg_next   = (cur_byte == ssip_pkg::CHAR_MINUS);
                        phase_next = ssip_pkg::PH_DIGIT;
                    end
                    else if (is_digit)
                    begin
                        mag_next   = (mag_x > mag_cap) ? mag_cap[ssip_pkg::MAG_W-1:0]
                                                       : mag_x[ssip_pkg::MAG_W-1:0];
                        phase_next = ssip_pkg::PH_DIGIT;
                    end
                    else if (!is_blank)
                    begin
                        phase_next = ssip_pkg::PH_STOP;
                    end
                end
                ssip_pkg::PH_DIGIT:
                begin
                    if (is_digit)
                    begin
                        mag_next = (mag_x > mag_cap) ? mag_cap[ssip_pkg::MAG_W-1:0]
                                                     : mag_x[ssip_pkg::MAG_W-1:0];
                    end
                    else
                    begin
                        phase_next = ssip_pkg::PH_STOP;
                    end
                end
                default: ;
            endcase
        end

        case (state_reg)
            ssip_pkg::ST_IDLE:
            begin
                rd_cnt_next = '0;
                phase_next  = ssip_pkg::PH_BLANK;
                neg_next    = 1'b0;
                mag_next    = '0;
                if (in_take)
                begin
                    if (s_axis_tuser == ssip_pkg::OP_TICK)
                    begin
                        kind_next = ssip_pkg::KIND_DRIVE;
                    end
                    else if (s_axis_tdata == ssip_pkg::CHAR_NEWLINE)
                    begin
                        kind_next = ssip_pkg::KIND_TARGET;
                    end
                    else
                    begin
                        ram_we                    = 1'b1;
                        line_valid_next[wpos_reg] = 1'b1;
                        wpos_next = (wpos_reg == AW'(ssip_pkg::LINE_DEPTH - 1))
                                  ? '0 : wpos_reg + 1'b1;
                    end
                end
            end
            ssip_pkg::ST_PARSE:
            begin
                pend_next   = 1'b1;
                rd_cnt_next = (rd_cnt_reg == AW'(ssip_pkg::LINE_DEPTH - 1))
                            ? rd_cnt_reg : rd_cnt_reg + 1'b1;
            end
            ssip_pkg::ST_PSET:
            begin
                setpoint_next   = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
                line_valid_next = '0;
                wpos_next       = '0;
            end
            ssip_pkg::ST_ERR:
            begin
                e_next  = ssip_pkg::ERR_W'(setpoint_reg)
                        - $signed({1'b0, ssip_pkg::TARGET_W'(drive_reg)});
                d1_next = ssip_pkg::D1_W'(e_next) - ssip_pkg::D1_W'(e1_reg);
                d2_next = ssip_pkg::D2_W'(e_next) - (ssip_pkg::D2_W'(e1_reg) <<< 1)
                        + ssip_pkg::D2_W'(e2_reg);
                e2_next  = e1_reg;
                e1_next  = e_next;
                acc_next = '0;
            end
            ssip_pkg::ST_MUL_P:
            begin
                prod_next = mul_a * mul_b;
            end
            ssip_pkg::ST_MUL_I, ssip_pkg::ST_MUL_D:
            begin
                prod_next = mul_a * mul_b;
                acc_next  = acc_reg + ssip_pkg::ACC_W'(prod_reg);
            end
            ssip_pkg::ST_ACC:
            begin
                acc_next = acc_reg + ssip_pkg::ACC_W'(prod_reg);
            end
            ssip_pkg::ST_DELTA:
            begin
                // shift toward zero: arithmetic shift rounds down, fix negatives
                delta_next = ssip_pkg::DELTA_W'(acc_reg >>> ssip_pkg::GAIN_FRAC_BITS)
                           + ssip_pkg::DELTA_W'(acc_reg[ssip_pkg::ACC_W-1] && low_nz);
            end
            ssip_pkg::ST_CLAMP:
            begin
                if (v_sum > $signed(ssip_pkg::VAL_W'(drive_upper_reg)))
                begin
                    drive_next = drive_upper_reg;
                end
                else if (v_sum < $signed(ssip_pkg::VAL_W'(drive_lower_reg)))
                begin
                    drive_next = drive_lower_reg;
                end
                else
                begin
                    drive_next = v_sum[ssip_pkg::DRIVE_W-1:0];
                end
            end
            ssip_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_data_next  = {setpoint_reg, drive_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssip_pkg::ST_IDLE;
            phase_reg      <= ssip_pkg::PH_BLANK;
            wpos_reg       <= '0;
            rd_cnt_reg     <= '0;
            line_valid_reg <= '0;
            pend_reg       <= 1'b0;
            byte_ok_reg    <= 1'b0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            kind_reg       <= ssip_pkg::KIND_DRIVE;
            out_valid_reg  <= 1'b0;
            setpoint_reg   <= '0;
            drive_reg      <= ssip_pkg::DRIVE_RESET;
            e1_reg         <= '0;
            e2_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            wpos_reg       <= wpos_next;
            rd_cnt_reg     <= rd_cnt_next;
            line_valid_reg <= line_valid_next;
            pend_reg       <= pend_next;
            byte_ok_reg    <= byte_ok_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            kind_reg       <= kind_next;
            out_valid_reg  <= out_valid_next;
            setpoint_reg   <= setpoint_next;
            drive_reg      <= drive_next;
            e1_reg         <= e1_next;
            e2_reg         <= e2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg        <= e_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        delta_reg    <= delta_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

endmodule
